// File: rtl/sbda_pkg.sv
// Shared types, constants and the double-dabble step for the decimal text converter.
package sbda_pkg;

    localparam int BIN_WIDTH       = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_WIDTH       = 4 * DIGITS;
    localparam int STEPS_PER_STAGE = 8;
    localparam int DABBLE_STAGES   = BIN_WIDTH / STEPS_PER_STAGE;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic                   neg;
        logic [BIN_WIDTH-1:0]   bin;
        logic [BCD_WIDTH-1:0]   bcd;
    } sbda_work_t;

    // One shift-and-add-3 step: binary bits move MSB first into the BCD field.
    function automatic sbda_work_t dabble_step(input sbda_work_t w);
        logic [BCD_WIDTH-1:0] b;
        sbda_work_t           r;
        b = w.bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[4*i +: 4] >= 4'd5) begin
                b[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        r.neg = w.neg;
        r.bcd = {b[BCD_WIDTH-2:0], w.bin[BIN_WIDTH-1]};
        r.bin = {w.bin[BIN_WIDTH-2:0], 1'b0};
        return r;
    endfunction

    // Position of the most significant nonzero digit, zero when all digits are zero.
    function automatic logic [3:0] lead_digit(input logic [BCD_WIDTH-1:0] bcd);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[4*i +: 4] != 4'd0) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/sbda_dabble_stage.sv
// One pipeline stage of the binary to BCD conversion, several dabble steps per stage.
module sbda_dabble_stage
    import sbda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sbda_work_t in_work,
    output logic       out_valid,
    input  logic       out_ready,
    output sbda_work_t out_work
);

    logic       valid_reg;
    sbda_work_t work_reg;
    sbda_work_t work_next;

    always_comb
    begin
        work_next = in_work;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            work_next = dabble_step(work_next);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

// File: rtl/sbda_serializer.sv
// Emits the sign and significant digits of one number, one character per cycle unless stalled.
module sbda_serializer
    import sbda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sbda_work_t in_work,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic                 busy_reg;
    logic                 sign_reg;
    logic [3:0]           pos_reg;
    logic [BCD_WIDTH-1:0] bcd_reg;
    logic [3:0]           digit;
    logic                 take;

    assign digit    = bcd_reg[{pos_reg, 2'b00} +: 4];
    assign m_tvalid = busy_reg;
    assign m_tdata  = sign_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digit});
    assign m_tlast  = !sign_reg && (pos_reg == 4'd0);
    assign take     = busy_reg && m_tready;
    assign in_ready = !busy_reg || (take && m_tlast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            pos_reg  <= 4'd0;
        end else if (in_ready) begin
            busy_reg <= in_valid;
            sign_reg <= in_work.neg;
            pos_reg  <= lead_digit(in_work.bcd);
        end else if (take) begin
            if (sign_reg) begin
                sign_reg <= 1'b0;
            end else begin
                pos_reg <= pos_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            bcd_reg <= in_work.bcd;
        end
    end

endmodule

// File: rtl/signed_binary_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Each item on the slave side is a 32-bit two's-complement integer; the master side returns its
// decimal text one character per item, most significant first, with a leading '-' for negative
// values, no leading zeros, "0" for zero, and tlast on the final character. An item passes an
// input stage that forms sign and magnitude, four binary to BCD stages of eight steps each, and
// the character serializer. The serializer sends one character per cycle while m_tready is high,
// and a number takes 1 to 11 characters; the next number is loaded in the cycle its last
// character is taken, while later numbers wait in the conversion stages.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character[7:0]
    output logic        m_tlast    // last
);

    logic       in_valid_reg;
    sbda_work_t in_work_reg;
    sbda_work_t in_work_next;

    logic       stg_valid [DABBLE_STAGES+1];
    logic       stg_ready [DABBLE_STAGES+1];
    sbda_work_t stg_work  [DABBLE_STAGES+1];

    always_comb
    begin
        in_work_next.neg = s_tdata[BIN_WIDTH-1];
        in_work_next.bin = s_tdata[BIN_WIDTH-1] ? (32'd0 - s_tdata) : s_tdata;
        in_work_next.bcd = '0;
    end

    assign s_tready = !in_valid_reg || stg_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_work_reg <= in_work_next;
        end
    end

    assign stg_valid[0] = in_valid_reg;
    assign stg_work[0]  = in_work_reg;

    for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
        sbda_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_work   (stg_work[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_work  (stg_work[g+1])
        );
    end

    sbda_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[DABBLE_STAGES]),
        .in_ready (stg_ready[DABBLE_STAGES]),
        .in_work  (stg_work[DABBLE_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A character that is not the last is always followed by another one.
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("character stream ended without tlast");

    // The sign never ends a number.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == CHAR_MINUS) |-> !m_tlast)
        else $error("minus sign flagged as last character");

    // Every character is a minus sign or a decimal digit.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CHAR_MINUS) || ((m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_NINE)))
        else $error("character outside the decimal alphabet");

endmodule

// File: sim/signed_binary_to_decimal_ascii_tb.sv
// Testbench for the signed 32-bit integer to decimal ASCII text converter.
module signed_binary_to_decimal_ascii_tb
    import sbda_pkg::*;
;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    class ascii_scoreboard;
        text_char_t expected_text[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_value(logic [31:0] value);
            logic [31:0] mag;
            logic [7:0]  digits [10];
            int          ndig;
            text_char_t  c;
            ndig = 0;
            mag = value[31] ? (32'd0 - value) : value;
            do begin
                digits[ndig] = CHAR_ZERO + 8'(mag % 32'd10);
                mag = mag / 32'd10;
                ndig++;
            end while (mag != 32'd0);
            if (value[31]) begin
                c.ch = CHAR_MINUS;
                c.last = 1'b0;
                expected_text.push_back(c);
            end
            for (int k = ndig - 1; k >= 0; k--) begin
                c.ch = digits[k];
                c.last = (k == 0);
                expected_text.push_back(c);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            text_char_t want;
            if (expected_text.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected character %h last %b", ch, last);
                end
                return;
            end
            want = expected_text.pop_front();
            if (ch !== want.ch || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %h last %b, got %h last %b",
                             want.ch, want.last, ch, last);
                end
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    ascii_scoreboard sb = new();
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    int sink_hold = 0;

    signed_binary_to_decimal_ascii dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_value(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_char(m_tdata, m_tlast);
            end
        end
    end

    initial begin
        int n;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (sink_hold > 0) begin
                m_tready <= 1'b0;
                n = sink_hold;
                sink_hold = 0;
                repeat (n) @(posedge clk);
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    task automatic send_value(logic [31:0] value);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        logic [31:0] pow;
        int          k;
        pow = 32'd1;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2: begin
                k = $urandom_range(0, 9);
                repeat (k) pow = pow * 32'd10;
                v = pow + 32'($urandom_range(0, 2)) - 32'd1;
            end
            3: begin
                k = $urandom_range(1, 9);
                repeat (k) pow = pow * 32'd10;
                v = $urandom % pow;
            end
            default: v = 32'h7FFFFFFF - 32'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = 32'd0 - v;
        end
        return v;
    endfunction

    initial begin
        logic [31:0] directed [];
        directed = '{
            32'd0, 32'd1, 32'hFFFFFFFF, 32'd9, 32'd10, 32'hFFFFFFF6, 32'd99, 32'd100,
            32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'd1000000000, 32'd999999999,
            32'hC4653601, 32'd123456789, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFB,
            32'd4294967295, 32'd1000000001
        };
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_value(directed[i]);
        repeat (90) send_value(random_value());

        src_idle = 1'b0;
        sink_hold = 300;
        repeat (30) send_value(random_value());
        s_tvalid <= 1'b0;
        wait_drained();
        src_idle = 1'b1;

        repeat (80) send_value(random_value());

        src_idle = 1'b0;
        sink_idle = 1'b0;
        repeat (40) send_value(random_value());
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
